/* rtl/opp_pkg.sv */
// Shared constants and types for the onset peak picker.
// Used by the divider and by the top level; depends on nothing.
package opp_pkg;

	localparam int MAX_HALF_WINDOW = 8;
	localparam int HIST_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
	localparam int HIDX_BITS       = $clog2(HIST_DEPTH);
	localparam int HW_BITS         = $clog2(MAX_HALF_WINDOW + 1);
	localparam int SAMPLE_BITS     = 16;
	localparam int FRAME_BITS      = 32;
	localparam int MAX_RESULTS     = 4;
	localparam int NRES_BITS       = $clog2(MAX_RESULTS + 1);

	// Divider operand widths: numerator holds a scaled difference or its square,
	// denominator holds the curvature magnitude or eight times it.
	localparam int DIV_NUM_BITS = 32;
	localparam int DIV_DEN_BITS = 20;
	localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);

	typedef logic [HIDX_BITS-1:0] hidx_t;

	typedef enum logic [1:0] {
		REG_LOCAL = 2'd0,
		REG_MEAN  = 2'd1,
		REG_DELTA = 2'd2,
		REG_GAP   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRAME,
		ST_RDL,
		ST_RDR,
		ST_CAP,
		ST_LOC_RD,
		ST_LOC_EV,
		ST_MEAN_RD,
		ST_MEAN_EV,
		ST_GAP,
		ST_DIV1,
		ST_DIV2,
		ST_EMIT,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

/* rtl/opp_div.sv */
// Bit-serial restoring divider with round-to-nearest, ties away from zero.
// Depends on opp_pkg for the operand widths.
module opp_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [opp_pkg::DIV_NUM_BITS-1:0]      num,
	input  logic [opp_pkg::DIV_DEN_BITS-1:0]      den,
	output logic                                  done,
	output logic [opp_pkg::DIV_NUM_BITS:0]        quo
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [opp_pkg::DIV_CNT_BITS-1:0]      cnt_q;
	logic [opp_pkg::DIV_NUM_BITS-1:0]      q_q;
	logic [opp_pkg::DIV_DEN_BITS-1:0]      rem_q;
	logic [opp_pkg::DIV_DEN_BITS-1:0]      den_q;
	logic [opp_pkg::DIV_DEN_BITS:0]        trial;
	logic                                  fits;
	logic [opp_pkg::DIV_DEN_BITS:0]        rem2;

	// One quotient bit per cycle: shift in the next numerator bit and try a subtract.
	assign trial = {rem_q, q_q[opp_pkg::DIV_NUM_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == opp_pkg::DIV_CNT_BITS'(opp_pkg::DIV_NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[opp_pkg::DIV_NUM_BITS-2:0], fits};
			rem_q <= fits ? opp_pkg::DIV_DEN_BITS'(trial - {1'b0, den_q})
			              : opp_pkg::DIV_DEN_BITS'(trial);
		end
	end

	// Round up when twice the remainder reaches the divisor.
	assign rem2 = {rem_q, 1'b0};
	assign done = done_q;
	assign quo  = {1'b0, q_q} + ((rem2 >= {1'b0, den_q}) ? 1'b1 : 1'b0);

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
`endif

endmodule

/* rtl/onset_peak_picker.sv */
// Onset peak picker: 17-entry sample ring, window scans and parabolic fit.
// Depends on opp_pkg and instantiates the shared divider opp_div.
// Each frame judged reads the candidate and its neighbours, scans the local window,
// then the mean window and the gap, and adds up to two divisions and an emit for a peak.
// An ordinary word judges at most one frame, a final word up to 8 frames; each word
// also passes the accept and closing states. The block takes one word at a time.
// Reset clears the sample count, the peak record and the handshake state; no clearing pass.
module onset_peak_picker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] sample,
	input  logic               final_sample,
	output logic               peak_valid,
	input  logic               peak_stall,
	output logic [31:0]        frame_index,
	output logic signed [15:0] sub_frame_offset,
	output logic signed [17:0] strength,
	output logic               last_in_run
);

	localparam int FB = opp_pkg::FRAME_BITS;
	localparam int HB = opp_pkg::HIDX_BITS;

	opp_pkg::state_t state_q, state_nx;

	// Configuration registers.
	logic [3:0]         cfg_local_q, cfg_mean_q;
	logic signed [15:0] cfg_delta_q;
	logic [15:0]        cfg_gap_q;
	logic               cfg_we;

	// Sample ring and bookkeeping.
	logic signed [15:0] mem [opp_pkg::HIST_DEPTH];
	logic signed [15:0] rdata_q;
	opp_pkg::hidx_t     raddr, wp_q, sidx_q;
	logic [FB-1:0]      count_q, s_q, last_q, f_q;
	logic               peak_seen_q, fin_q;
	logic [opp_pkg::NRES_BITS-1:0] nres_q;

	// Per-frame working registers.
	opp_pkg::hidx_t     jf_q, j_q, loc_lo_q, loc_hi_q, mean_lo_q, mean_hi_q;
	logic signed [15:0] c_q, l_q, r_q;
	logic signed [16:0] cd_q;
	logic signed [22:0] acc_q, acc_nx;
	logic [16:0]        ad_q;
	logic               dneg_q, oneg_q;
	logic [31:0]        sq_q;
	logic [32:0]        om_q;

	// Result staging: newest result, pending result and output register.
	logic [FB-1:0]      res_frame_q, pend_frame_q, out_frame_q;
	logic signed [15:0] res_off_q, pend_off_q, out_off_q;
	logic signed [17:0] res_str_q, pend_str_q, out_str_q;
	logic               pend_vld_q, out_vld_q, out_last_q, out_free, out_load;

	// Combinational helpers.
	logic [HB-1:0]      lw, mw, hw;
	logic [15:0]        gap16;
	logic               accept, full, go, more;
	logic [FB-1:0]      s_new;
	opp_pkg::hidx_t     jf_init, loc_sum, mean_sum;
	logic signed [17:0] d18;
	logic signed [16:0] diff17;
	logic [17:0]        d_mag;
	logic [16:0]        diff_mag;
	logic [16:0]        ad;
	logic [15:0]        adf;
	logic               dzero, gap_fail, loc_reject;
	logic               div_start, div_done;
	logic [opp_pkg::DIV_NUM_BITS-1:0] div_num;
	logic [opp_pkg::DIV_DEN_BITS-1:0] div_den;
	logic [opp_pkg::DIV_NUM_BITS:0]   div_quo;
	logic signed [15:0] off_sat;
	logic [18:0]        smc;
	logic signed [19:0] str20;
	logic signed [17:0] str_sat;

	// Ring position of the sample j places before the newest one.
	function automatic opp_pkg::hidx_t ring_addr(opp_pkg::hidx_t base, opp_pkg::hidx_t j);
		opp_pkg::hidx_t a;
		if (base >= j) begin
			a = base - j;
		end else begin
			a = opp_pkg::hidx_t'(opp_pkg::HIST_DEPTH) + base - j;
		end
		return a;
	endfunction

	// Register port.
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_local_q <= 4'd3;
			cfg_mean_q  <= 4'd3;
			cfg_delta_q <= '0;
			cfg_gap_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (opp_pkg::reg_idx_t'(paddr[3:2]))
				opp_pkg::REG_LOCAL: cfg_local_q <= pwdata[3:0];
				opp_pkg::REG_MEAN:  cfg_mean_q  <= pwdata[3:0];
				opp_pkg::REG_DELTA: cfg_delta_q <= pwdata[15:0];
				opp_pkg::REG_GAP:   cfg_gap_q   <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (opp_pkg::reg_idx_t'(paddr[3:2]))
			opp_pkg::REG_LOCAL: prdata = {28'd0, cfg_local_q};
			opp_pkg::REG_MEAN:  prdata = {28'd0, cfg_mean_q};
			opp_pkg::REG_DELTA: prdata = 32'(cfg_delta_q);
			opp_pkg::REG_GAP:   prdata = {16'd0, cfg_gap_q};
		endcase
	end

	// Effective windows and gap.
	always_comb begin
		lw = (cfg_local_q > 4'(opp_pkg::MAX_HALF_WINDOW)) ? HB'(opp_pkg::MAX_HALF_WINDOW)
		                                                 : HB'(cfg_local_q);
		mw = (cfg_mean_q > 4'(opp_pkg::MAX_HALF_WINDOW)) ? HB'(opp_pkg::MAX_HALF_WINDOW)
		                                                : HB'(cfg_mean_q);
		hw = (lw > mw) ? lw : mw;
		if (hw == '0) begin
			hw = HB'(1);
		end
		gap16 = (cfg_gap_q == '0) ? 16'd1 : cfg_gap_q;
	end

	// Decide at accept time which frames this word makes ready.
	// Once the counter is full, an ordinary word is dropped without judging.
	assign accept = sample_valid & ~sample_stall;
	assign full   = &count_q;
	always_comb begin
		s_new = full ? count_q - 1'b1 : count_q;
		if (final_sample) begin
			go      = s_new >= FB'(2);
			jf_init = (s_new > FB'(hw)) ? hw : HB'(s_new[HB-1:0] - 1'b1);
		end else begin
			go      = !full && (s_new >= FB'(hw) + 1'b1);
			jf_init = hw;
		end
	end

	// Window edges for the frame about to start, clipped at both signal ends.
	assign loc_sum  = jf_q + lw;
	assign mean_sum = jf_q + mw;

	// Curvature and slope of the three samples around the candidate.
	always_comb begin
		d18      = 18'(l_q) - (18'(c_q) <<< 1) + 18'(r_q);
		diff17   = 17'(l_q) - 17'(r_q);
		d_mag    = d18[17] ? 18'(-d18) : 18'(d18);
		diff_mag = diff17[16] ? 17'(-diff17) : 17'(diff17);
		ad       = d_mag[16:0];
		adf      = diff_mag[15:0];
		dzero    = (d18 == '0);
	end

	assign gap_fail   = peak_seen_q && ((f_q <= last_q) || ((f_q - last_q) <= FB'(gap16)));
	assign loc_reject = rdata_q > c_q;
	assign acc_nx     = acc_q + 23'(cd_q) - 23'(rdata_q);
	assign more       = fin_q && (jf_q > HB'(1)) && (nres_q < opp_pkg::NRES_BITS'(opp_pkg::MAX_RESULTS));
	assign out_free   = ~out_vld_q | ~peak_stall;
	assign out_load   = ((state_q == opp_pkg::ST_EMIT) || (state_q == opp_pkg::ST_DONE)) &&
	                    pend_vld_q && out_free;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			opp_pkg::ST_IDLE:    if (accept) state_nx = go ? opp_pkg::ST_FRAME : opp_pkg::ST_DONE;
			opp_pkg::ST_FRAME:   state_nx = opp_pkg::ST_RDL;
			opp_pkg::ST_RDL:     state_nx = opp_pkg::ST_RDR;
			opp_pkg::ST_RDR:     state_nx = opp_pkg::ST_CAP;
			opp_pkg::ST_CAP:     state_nx = opp_pkg::ST_LOC_RD;
			opp_pkg::ST_LOC_RD:  state_nx = opp_pkg::ST_LOC_EV;
			opp_pkg::ST_LOC_EV: begin
				priority if (loc_reject) state_nx = opp_pkg::ST_NEXT;
				else if (j_q == loc_hi_q) state_nx = opp_pkg::ST_MEAN_RD;
				else state_nx = opp_pkg::ST_LOC_RD;
			end
			opp_pkg::ST_MEAN_RD: state_nx = opp_pkg::ST_MEAN_EV;
			opp_pkg::ST_MEAN_EV: begin
				if (j_q == mean_hi_q) begin
					state_nx = acc_nx[22] ? opp_pkg::ST_NEXT : opp_pkg::ST_GAP;
				end else begin
					state_nx = opp_pkg::ST_MEAN_RD;
				end
			end
			opp_pkg::ST_GAP: begin
				priority if (gap_fail) state_nx = opp_pkg::ST_NEXT;
				else if (dzero) state_nx = opp_pkg::ST_EMIT;
				else state_nx = opp_pkg::ST_DIV1;
			end
			opp_pkg::ST_DIV1:    if (div_done) state_nx = opp_pkg::ST_DIV2;
			opp_pkg::ST_DIV2:    if (div_done) state_nx = opp_pkg::ST_EMIT;
			opp_pkg::ST_EMIT:    if (!pend_vld_q || out_free) state_nx = opp_pkg::ST_NEXT;
			opp_pkg::ST_NEXT:    state_nx = more ? opp_pkg::ST_FRAME : opp_pkg::ST_DONE;
			opp_pkg::ST_DONE:    if (!pend_vld_q || out_free) state_nx = opp_pkg::ST_IDLE;
			default:             state_nx = opp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: ring address, stall and divider control.
	always_comb begin
		sample_stall = (state_q != opp_pkg::ST_IDLE);
		unique case (state_q)
			opp_pkg::ST_RDL:     raddr = ring_addr(sidx_q, jf_q + 1'b1);
			opp_pkg::ST_RDR:     raddr = ring_addr(sidx_q, jf_q - 1'b1);
			opp_pkg::ST_LOC_RD,
			opp_pkg::ST_MEAN_RD: raddr = ring_addr(sidx_q, j_q);
			default:             raddr = ring_addr(sidx_q, jf_q);
		endcase
		div_start = ((state_q == opp_pkg::ST_GAP) && !gap_fail && !dzero) ||
		            ((state_q == opp_pkg::ST_DIV1) && div_done);
		if (state_q == opp_pkg::ST_GAP) begin
			div_num = {3'd0, adf, 13'd0};
			div_den = {3'd0, ad};
		end else begin
			div_num = sq_q;
			div_den = {ad_q, 3'd0};
		end
	end

	opp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Saturated offset and strength from the two quotients.
	always_comb begin
		if (oneg_q) begin
			off_sat = (om_q >= 33'd32768) ? -16'sd32768 : $signed(16'd0 - om_q[15:0]);
		end else begin
			off_sat = (om_q >= 33'd32767) ? 16'sd32767 : $signed(om_q[15:0]);
		end
		smc   = (div_quo > 33'h40000) ? 19'h40000 : div_quo[18:0];
		str20 = dneg_q ? 20'(c_q) + $signed(20'(smc)) : 20'(c_q) - $signed(20'(smc));
		priority if (str20 > 20'sd131071) str_sat = 18'sd131071;
		else if (str20 < -20'sd131072) str_sat = -18'sd131072;
		else str_sat = str20[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Sample ring: one write per stored word, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[wp_q] <= sample;
		end
		rdata_q <= mem[raddr];
	end

	// Control state: counters, peak record and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wp_q        <= '0;
			sidx_q      <= '0;
			last_q      <= '0;
			peak_seen_q <= 1'b0;
			fin_q       <= 1'b0;
			nres_q      <= '0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			// The output register loads from the pending slot or empties when taken.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!peak_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				opp_pkg::ST_IDLE: begin
					if (accept) begin
						fin_q  <= final_sample;
						nres_q <= '0;
						if (!full) begin
							count_q <= count_q + 1'b1;
							sidx_q  <= wp_q;
							wp_q    <= (wp_q == HB'(opp_pkg::HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						end
					end
				end
				opp_pkg::ST_GAP: begin
					if (!gap_fail) begin
						last_q      <= f_q;
						peak_seen_q <= 1'b1;
						nres_q      <= nres_q + 1'b1;
					end
				end
				opp_pkg::ST_EMIT: begin
					if (!pend_vld_q) begin
						pend_vld_q <= 1'b1;
					end
				end
				opp_pkg::ST_DONE: begin
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							pend_vld_q <= 1'b0;
						end
						// The last word of a signal returns the stream state to reset.
						if (fin_q) begin
							count_q     <= '0;
							wp_q        <= '0;
							sidx_q      <= '0;
							last_q      <= '0;
							peak_seen_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the frame judge.
	always_ff @(posedge clk) begin
		unique case (state_q)
			opp_pkg::ST_IDLE: begin
				if (accept) begin
					s_q  <= s_new;
					jf_q <= jf_init;
				end
			end
			opp_pkg::ST_FRAME: begin
				f_q       <= s_q - FB'(jf_q);
				loc_lo_q  <= (jf_q >= lw) ? jf_q - lw : '0;
				loc_hi_q  <= (s_q < FB'(loc_sum)) ? s_q[HB-1:0] : loc_sum;
				mean_lo_q <= (jf_q >= mw) ? jf_q - mw : '0;
				mean_hi_q <= (s_q < FB'(mean_sum)) ? s_q[HB-1:0] : mean_sum;
			end
			opp_pkg::ST_RDL: c_q <= rdata_q;
			opp_pkg::ST_RDR: l_q <= rdata_q;
			opp_pkg::ST_CAP: begin
				r_q  <= rdata_q;
				cd_q <= 17'(c_q) - 17'(cfg_delta_q);
				j_q  <= loc_lo_q;
			end
			opp_pkg::ST_LOC_EV: begin
				if (j_q == loc_hi_q) begin
					j_q   <= mean_lo_q;
					acc_q <= '0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			opp_pkg::ST_MEAN_EV: begin
				// Sum of (centre - delta - sample) over the mean window must end non-negative.
				acc_q <= acc_nx;
				j_q   <= j_q + 1'b1;
			end
			opp_pkg::ST_GAP: begin
				ad_q        <= ad;
				dneg_q      <= d18[17];
				oneg_q      <= diff17[16] ^ d18[17];
				sq_q        <= 32'(adf) * 32'(adf);
				res_frame_q <= f_q;
				res_off_q   <= '0;
				res_str_q   <= 18'(c_q);
			end
			opp_pkg::ST_DIV1: if (div_done) om_q <= div_quo;
			opp_pkg::ST_DIV2: begin
				if (div_done) begin
					res_off_q <= off_sat;
					res_str_q <= str_sat;
				end
			end
			opp_pkg::ST_EMIT: begin
				if (!pend_vld_q || out_free) begin
					pend_frame_q <= res_frame_q;
					pend_off_q   <= res_off_q;
					pend_str_q   <= res_str_q;
				end
				if (pend_vld_q && out_free) begin
					out_frame_q <= pend_frame_q;
					out_off_q   <= pend_off_q;
					out_str_q   <= pend_str_q;
					out_last_q  <= 1'b0;
				end
			end
			opp_pkg::ST_NEXT: if (more) jf_q <= jf_q - 1'b1;
			opp_pkg::ST_DONE: begin
				if (pend_vld_q && out_free) begin
					out_frame_q <= pend_frame_q;
					out_off_q   <= pend_off_q;
					out_str_q   <= pend_str_q;
					out_last_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign peak_valid       = out_vld_q;
	assign frame_index      = out_frame_q;
	assign sub_frame_offset = out_off_q;
	assign strength         = out_str_q;
	assign last_in_run      = out_last_q;

`ifndef ASSERT_OFF
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == opp_pkg::ST_IDLE |-> !pend_vld_q)
		else $error("result left pending while idle");

	a_result_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= opp_pkg::NRES_BITS'(opp_pkg::MAX_RESULTS))
		else $error("too many results for one word");

	a_frame_offset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == opp_pkg::ST_FRAME |->
			(jf_q != '0) && (jf_q <= HB'(opp_pkg::MAX_HALF_WINDOW)))
		else $error("frame offset outside the ring window");
`endif

endmodule

/* dv/tb.sv */
// Testbench for onset_peak_picker: directed table plus random signals,
// checked word by word against a built-in peak predictor.
// Depends on opp_pkg and the onset_peak_picker RTL.
`timescale 1ns / 100ps

module tb;

	localparam int HDEPTH = 17;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic [31:0] frame;
		logic [15:0] offset;
		logic [17:0] strength;
		logic        last;
	} peak_t;

	typedef struct {
		logic [15:0] value;
		logic        fin;
		logic        has_peak;
		logic [31:0] frame;
	} stim_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic sample_valid, sample_stall;
	logic signed [15:0] sample;
	logic final_sample;
	logic peak_valid, peak_stall;
	logic [31:0] frame_index;
	logic signed [15:0] sub_frame_offset;
	logic signed [17:0] strength;
	logic last_in_run;

	onset_peak_picker dut (.*);

	// Predictor copy of the registers and the signal state.
	int unsigned cfg_local, cfg_mean, cfg_gap;
	longint cfg_delta;
	longint hist_mem [HDEPTH];
	longint unsigned n_samples, last_peak;
	bit seen_peak;

	peak_t expected_peaks [$];
	int errors;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic longint rnd_div(longint unsigned num, longint unsigned den);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		if (r >= den - r) q++;
		return q;
	endfunction

	function automatic longint hval(longint unsigned idx);
		return hist_mem[idx % HDEPTH];
	endfunction

	function automatic void clear_signal();
		foreach (hist_mem[i]) hist_mem[i] = 0;
		n_samples = 0;
		last_peak = 0;
		seen_peak = 0;
	endfunction

	// Judge one frame against the windows; queue a peak when it qualifies.
	function automatic bit judge_frame(longint unsigned f, longint unsigned last_f);
		longint unsigned lw, mw, gp, lo, hi, k, adf, ad, om, sm;
		longint c, sum, cnt, l, r, d, diff, off, st;
		peak_t p;
		lw = cfg_local > 8 ? 8 : cfg_local;
		mw = cfg_mean > 8 ? 8 : cfg_mean;
		gp = cfg_gap == 0 ? 1 : cfg_gap;
		c = hval(f);
		lo = f >= lw ? f - lw : 0;
		hi = f + lw < last_f ? f + lw : last_f;
		for (k = lo; k <= hi; k++)
			if (k != f && hval(k) > c) return 0;
		lo = f >= mw ? f - mw : 0;
		hi = f + mw < last_f ? f + mw : last_f;
		sum = 0;
		for (k = lo; k <= hi; k++) sum += hval(k);
		cnt = hi - lo + 1;
		if (c * cnt < sum + cfg_delta * cnt) return 0;
		if (seen_peak && (f <= last_peak || f - last_peak <= gp)) return 0;
		l = hval(f - 1);
		r = hval(f + 1);
		d = l - 2 * c + r;
		diff = l - r;
		off = 0;
		st = c;
		if (d != 0) begin
			ad = d < 0 ? -d : d;
			adf = diff < 0 ? -diff : diff;
			om = rnd_div(adf << 13, ad);
			sm = rnd_div(adf * adf, ad * 8);
			off = ((diff < 0) != (d < 0)) ? -longint'(om) : longint'(om);
			st = d < 0 ? c + longint'(sm) : c - longint'(sm);
		end
		if (off < -32768) off = -32768;
		if (off > 32767) off = 32767;
		if (st < -131072) st = -131072;
		if (st > 131071) st = 131071;
		p.frame = f[31:0];
		p.offset = off[15:0];
		p.strength = st[17:0];
		p.last = 0;
		expected_peaks = {expected_peaks, p};
		last_peak = f;
		seen_peak = 1;
		return 1;
	endfunction

	// Advance the predictor by one accepted word.
	function automatic void predict_peaks(logic [15:0] value, logic fin);
		longint unsigned h, m, s, f;
		int n;
		h = cfg_local > 8 ? 8 : cfg_local;
		m = cfg_mean > 8 ? 8 : cfg_mean;
		if (m > h) h = m;
		if (h < 1) h = 1;
		n = 0;
		if (n_samples < 64'hFFFF_FFFF) begin
			hist_mem[n_samples % HDEPTH] = longint'(signed'(value));
			n_samples++;
		end else if (!fin) return;
		s = n_samples - 1;
		if (!fin) begin
			if (s >= h + 1 && judge_frame(s - h, s)) n = 1;
		end else if (s >= 2) begin
			for (f = (s > h ? s - h : 1); f < s; f++)
				if (n < 4 && judge_frame(f, s)) n++;
		end
		if (n > 0) expected_peaks[$].last = 1;
		if (fin) clear_signal();
	endfunction

	// Receiver: stall pattern changes mode now and then, including none.
	int stall_mode;
	initial begin
		peak_stall = 1;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: peak_stall <= 0;
				1: peak_stall <= ($urandom_range(0, 3) == 0);
				2: peak_stall <= ($urandom_range(0, 1) == 0);
				default: peak_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		peak_t got, want;
		if (arst_n && peak_valid && !peak_stall) begin
			got = '{frame_index, sub_frame_offset, strength, last_in_run};
			if (expected_peaks.size() == 0) begin
				$display("%0t: unexpected peak frame %0d", $time, frame_index);
				errors++;
			end else begin
				want = expected_peaks.pop_front();
				if (got !== want) begin
					$display("%0t: expected frame %0d off %0d str %0d last %0b", $time,
						want.frame, signed'(want.offset), signed'(want.strength), want.last);
					$display("%0t: actual   frame %0d off %0d str %0d last %0b", $time,
						got.frame, signed'(got.offset), signed'(got.strength), got.last);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(opp_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			opp_pkg::REG_LOCAL: cfg_local = value[3:0];
			opp_pkg::REG_MEAN:  cfg_mean = value[3:0];
			opp_pkg::REG_DELTA: cfg_delta = longint'(signed'(value[15:0]));
			default:            cfg_gap = value[15:0];
		endcase
	endtask

	// Send one word, holding it until accepted; then update the predictor.
	task automatic send_word(logic [15:0] value, logic fin);
		@(negedge clk);
		sample_valid <= 1;
		sample <= value;
		final_sample <= fin;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		predict_peaks(value, fin);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		sample_valid <= 0;
	endtask

	// Wait for every expected peak, then let the block settle before a write.
	task automatic drain();
		drop_valid();
		while (expected_peaks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random signal: a smooth bumpy shape with occasional extreme noise.
	task automatic send_signal(int len);
		int base, burst;
		logic [15:0] v;
		burst = $urandom_range(1, 8);
		base = $urandom_range(0, 4000);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: v = 16'($urandom);
				1: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				default: begin
					base += $signed($urandom_range(0, 3000)) - 1500;
					if (base > 32767) base = 32767;
					if (base < -32768) base = -32768;
					v = base[15:0];
				end
			endcase
			send_word(v, i == len - 1);
			if (--burst == 0) begin
				drop_valid();
				repeat ($urandom_range(0, 12)) @(posedge clk);
				burst = $urandom_range(1, 10);
			end
		end
	endtask

	stim_row_t directed [$];
	int items;

	initial begin
		errors = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		sample_valid = 0;
		sample = 0;
		final_sample = 0;
		cfg_local = 3;
		cfg_mean = 3;
		cfg_delta = 0;
		cfg_gap = 1;
		clear_signal();
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: short signals, a single clear peak at the extremes, a flat run and a zigzag.
		directed = '{
			'{16'sd100, 1'b0, 1'b0, 32'd0},
			'{16'sd200, 1'b1, 1'b0, 32'd0},
			'{16'h8000, 1'b0, 1'b0, 32'd0},
			'{16'h7FFF, 1'b0, 1'b0, 32'd0},
			'{16'h8000, 1'b1, 1'b1, 32'd1},
			'{16'sd0, 1'b0, 1'b0, 32'd0},
			'{16'sd0, 1'b0, 1'b0, 32'd0},
			'{16'sd0, 1'b0, 1'b0, 32'd0},
			'{16'sd0, 1'b1, 1'b0, 32'd0},
			'{16'sd10, 1'b0, 1'b0, 32'd0},
			'{16'sd50, 1'b0, 1'b0, 32'd0},
			'{16'sd20, 1'b0, 1'b0, 32'd0},
			'{16'sd60, 1'b0, 1'b0, 32'd0},
			'{16'sd5, 1'b0, 1'b0, 32'd0},
			'{16'sd80, 1'b0, 1'b0, 32'd0},
			'{16'sd1, 1'b0, 1'b0, 32'd0},
			'{16'sd90, 1'b0, 1'b0, 32'd0},
			'{16'sd0, 1'b1, 1'b0, 32'd0}
		};
		foreach (directed[i]) begin
			send_word(directed[i].value, directed[i].fin);
			// Rows with a known frame are checked against the typed value.
			if (directed[i].has_peak && (expected_peaks.size() == 0 ||
					expected_peaks[$].frame != directed[i].frame)) begin
				$display("%0t: expected directed peak at frame %0d, actual none", $time,
					directed[i].frame);
				errors++;
			end
		end
		drain();

		// Zero windows and zero gap, then oversized windows and extreme delta, then the widest gap.
		write_reg(opp_pkg::REG_LOCAL, 0);
		write_reg(opp_pkg::REG_MEAN, 0);
		write_reg(opp_pkg::REG_GAP, 0);
		send_signal(12);
		drain();
		write_reg(opp_pkg::REG_LOCAL, 15);
		write_reg(opp_pkg::REG_MEAN, 15);
		write_reg(opp_pkg::REG_DELTA, 32'h0000_8000);
		send_signal(20);
		drain();
		write_reg(opp_pkg::REG_DELTA, 32'h0000_7FFF);
		write_reg(opp_pkg::REG_GAP, 65535);
		send_signal(20);
		drain();

		// Random phases with random settings, mostly mild ones.
		items = 0;
		while (items < 290) begin
			write_reg(opp_pkg::REG_LOCAL, $urandom_range(0, 9));
			write_reg(opp_pkg::REG_MEAN, $urandom_range(0, 9));
			write_reg(opp_pkg::REG_DELTA, $urandom_range(0, 3) == 0 ? $urandom :
				32'($signed($urandom_range(0, 2000)) - 1000));
			write_reg(opp_pkg::REG_GAP,
				$urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 4));
			for (int s = 0; s < 3; s++) begin
				int len;
				len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
				send_signal(len);
				items += len;
			end
			drain();
		end

		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
